[sv/lbf_pkg.sv]
// shared types, constants and helpers of the learning bridge forwarding block
package lbf_pkg;

    localparam int HOST_W     = 8;
    localparam int PORT_W     = 3;
    localparam int MASK_W     = 8;
    localparam int PIU_W      = 4;
    localparam int HOST_SPACE = 2 ** HOST_W;

    localparam int HOST_COUNT_DEF = 256;
    localparam int PORT_COUNT     = 8;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_TUSER_W  = 2;

    // register select, taken from the word address bit
    localparam logic REG_PORTS_IN_USE = 1'b0;
    localparam logic REG_BLOCKED      = 1'b1;

    localparam logic [PIU_W-1:0]  PIU_RESET     = 4'd8;
    localparam logic [MASK_W-1:0] BLOCKED_RESET = 8'd0;

    typedef struct packed {
        logic [PIU_W-1:0]  ports_in_use;
        logic [MASK_W-1:0] blocked_ports;
    } t_cfg;

    typedef struct packed {
        logic [PORT_W-1:0] arrival_port;
        logic [HOST_W-1:0] dest_host;
        logic [HOST_W-1:0] source_host;
    } t_frame;

    typedef struct packed {
        logic              source_learned;
        logic              dest_known;
        logic [MASK_W-1:0] egress_mask;
    } t_result;

    // ports that are present and not blocked
    function automatic logic [MASK_W-1:0] usable_mask(input t_cfg cfg);
        int                n;
        logic [MASK_W-1:0] m;
        n = int'(cfg.ports_in_use);
        if (n > PORT_COUNT) begin
            n = PORT_COUNT;
        end
        for (int p = 0; p < MASK_W; p++) begin
            m[p] = (p < n);
        end
        return m & ~cfg.blocked_ports;
    endfunction

endpackage

[sv/lbf_ram.sv]
// generic single-write, single-read ram with registered read data
module lbf_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lbf_cfg.sv]
// apb register file holding the port count and the blocked port mask
module lbf_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [lbf_pkg::APB_AW-1:0] i_paddr,
    input  logic [lbf_pkg::APB_DW-1:0] i_pwdata,
    output logic [lbf_pkg::APB_DW-1:0] o_prdata,
    output logic                       o_pready,
    output lbf_pkg::t_cfg              o_cfg
);

    lbf_pkg::t_cfg r_cfg;
    logic          wr;
    logic          sel;

    assign wr  = i_psel && i_penable && i_pwrite;
    assign sel = i_paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ports_in_use  <= lbf_pkg::PIU_RESET;
            r_cfg.blocked_ports <= lbf_pkg::BLOCKED_RESET;
        end else if (wr) begin
            case (sel)
                lbf_pkg::REG_PORTS_IN_USE: begin
                    r_cfg.ports_in_use <= i_pwdata[lbf_pkg::PIU_W-1:0];
                end
                lbf_pkg::REG_BLOCKED: begin
                    r_cfg.blocked_ports <= i_pwdata[lbf_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (sel)
            lbf_pkg::REG_PORTS_IN_USE: o_prdata = lbf_pkg::APB_DW'(r_cfg.ports_in_use);
            lbf_pkg::REG_BLOCKED:      o_prdata = lbf_pkg::APB_DW'(r_cfg.blocked_ports);
            default:                   o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

endmodule

[sv/lbf_core.sv]
// learn and forward pipeline: input register, host table, decision, result register
module lbf_core #(
    parameter int HOST_COUNT = lbf_pkg::HOST_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lbf_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lbf_pkg::t_frame  i_in_frame,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lbf_pkg::t_result o_out_result
);

    localparam int TBL_DEPTH = (HOST_COUNT < lbf_pkg::HOST_SPACE) ?
                               HOST_COUNT : lbf_pkg::HOST_SPACE;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int CMP_W     = lbf_pkg::HOST_W + 1;

    logic                      r_s1_valid;
    lbf_pkg::t_frame           r_s1;
    logic                      r_out_valid;
    lbf_pkg::t_result          r_out;
    logic [TBL_DEPTH-1:0]      r_vld;
    logic                      r_byp_en;
    logic [AW-1:0]             r_byp_addr;
    logic [lbf_pkg::PORT_W-1:0] r_byp_port;

    logic                       out_ready;
    logic                       s1_adv;
    logic                       in_fire;
    logic [lbf_pkg::MASK_W-1:0] usable;
    logic [lbf_pkg::MASK_W-1:0] port_bit;
    logic [lbf_pkg::MASK_W-1:0] to_bit;
    logic                       arrive_ok;
    logic                       src_in;
    logic                       dst_in;
    logic [AW-1:0]              src_idx;
    logic [AW-1:0]              dst_idx;
    logic                       learn;
    logic                       self_hit;
    logic                       dst_valid;
    logic [lbf_pkg::PORT_W-1:0] rd_port;
    logic [lbf_pkg::PORT_W-1:0] to_port;
    logic                       we;
    lbf_pkg::t_result           n_out;

    assign out_ready  = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_in_ready = !r_s1_valid || out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign usable    = lbf_pkg::usable_mask(i_cfg);
    assign port_bit  = lbf_pkg::MASK_W'(1) << r_s1.arrival_port;
    assign arrive_ok = |(usable & port_bit);

    assign src_in  = {1'b0, r_s1.source_host} < CMP_W'(TBL_DEPTH);
    assign dst_in  = {1'b0, r_s1.dest_host}   < CMP_W'(TBL_DEPTH);
    assign src_idx = r_s1.source_host[AW-1:0];
    assign dst_idx = r_s1.dest_host[AW-1:0];

    assign learn     = arrive_ok && src_in && !r_vld[src_idx];
    // a frame addressed to the host it just taught us
    assign self_hit  = learn && dst_in && (src_idx == dst_idx);
    assign dst_valid = dst_in && (r_vld[dst_idx] || self_hit);

    // table data was read when this word was accepted; a learn committed at
    // that same edge is not in it yet
    always_comb begin
        if (self_hit) begin
            to_port = r_s1.arrival_port;
        end else if (r_byp_en && (r_byp_addr == dst_idx)) begin
            to_port = r_byp_port;
        end else begin
            to_port = rd_port;
        end
    end

    assign to_bit = lbf_pkg::MASK_W'(1) << to_port;

    always_comb begin
        n_out = '0;
        if (arrive_ok) begin
            n_out.source_learned = learn;
            if (dst_valid) begin
                n_out.dest_known = 1'b1;
                if (to_port != r_s1.arrival_port) begin
                    n_out.egress_mask = to_bit & usable;
                end
            end else begin
                n_out.egress_mask = usable & ~port_bit;
            end
        end
    end

    assign we = s1_adv && learn;

    lbf_ram #(
        .WIDTH (lbf_pkg::PORT_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (src_idx),
        .i_wdata (r_s1.arrival_port),
        .i_re    (in_fire),
        .i_raddr (i_in_frame.dest_host[AW-1:0]),
        .o_rdata (rd_port)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_byp_en    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_byp_en   <= we;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (we) begin
                r_vld[src_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1       <= i_in_frame;
            r_byp_addr <= src_idx;
            r_byp_port <= r_s1.arrival_port;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule

[sv/learning_bridge_forward.sv]
// top level of the learning bridge forwarding block
// path: an accepted frame is held in the input register, then its result word in the result register
// throughput: one frame per cycle unless the result stream stalls; the host table ram takes one read
//   (destination, on accept) and one write (learn, as the frame leaves the input register) each cycle
// reset: synchronous active low; clears the host valid flops, both stages and the
//   registers (ports_in_use 8, blocked_ports 0), with no clearing pass
module learning_bridge_forward #(
    parameter int HOST_COUNT = lbf_pkg::HOST_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input frame stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // source_host [7:0], dest_host [15:8], arrival_port [18:16], zero pad [23:19]
    input  logic [lbf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // forwarding result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // egress_mask [7:0]
    output logic [lbf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // dest_known [0], source_learned [1]
    output logic [lbf_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    // register port: ports_in_use at 0x0, blocked_ports at 0x4
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbf_pkg::APB_AW-1:0]      paddr,
    input  logic [lbf_pkg::APB_DW-1:0]      pwdata,
    output logic [lbf_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    lbf_pkg::t_cfg    cfg;
    lbf_pkg::t_frame  in_frame;
    lbf_pkg::t_result out_result;

    // the user must change register values only while no frame is in flight; the block does not enforce it
    lbf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    // unpack the incoming word, padding bits are dropped
    assign in_frame.source_host  = s_axis_tdata[7:0];
    assign in_frame.dest_host    = s_axis_tdata[15:8];
    assign in_frame.arrival_port = s_axis_tdata[18:16];

    // input register, host table lookup and learn, result register
    lbf_core #(
        .HOST_COUNT (HOST_COUNT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_frame   (in_frame),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_result (out_result)
    );

    // flags ride in tuser, the port mask in tdata
    assign m_axis_tdata    = out_result.egress_mask;
    assign m_axis_tuser[0] = out_result.dest_known;
    assign m_axis_tuser[1] = out_result.source_learned;

endmodule

[sv/lbf_checker.sv]
// port-level checks of the learning bridge forwarding block and their bind
module lbf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lbf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [lbf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a known destination goes to at most one port
    a_known_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> $onehot0(m_axis_tdata))
        else $error("known destination sent to several ports");

    // no result appears without a frame behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_acc ##1 (!s_acc && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result without an accepted frame");

endmodule

bind learning_bridge_forward lbf_checker u_lbf_checker (.*);
